[hdl/timer_prescale_load_search_core_macros.svh]
`ifndef TIMER_PRESCALE_LOAD_SEARCH_CORE_MACROS_SVH
`define TIMER_PRESCALE_LOAD_SEARCH_CORE_MACROS_SVH

// checked while out of reset
`define TPLS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tpls assertion failed");

// checked at every edge, reset included
`define TPLS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tpls assertion failed");

`endif

[hdl/tpls_pkg.sv]
`timescale 1ns / 1ps

package tpls_pkg;

  localparam int unsigned ErrW = 9;
  localparam int unsigned DivW = 9;
  localparam int unsigned QW   = 16;

  typedef struct packed {
    logic        operation;
    logic [31:0] requested_count;
  } tpls_in_t;

  typedef struct packed {
    logic [7:0]  prescale_value;
    logic [31:0] load_value;
    logic [31:0] remainder;
    logic        fit_found;
  } tpls_out_t;

  typedef struct packed {
    logic            valid;
    logic            mode;
    logic            match;
    logic [31:0]     count;
    logic            fit;
    logic [ErrW-1:0] err;
    logic [DivW-1:0] div;
    logic [QW-1:0]   q;
  } tpls_pipe_t;

endpackage

[hdl/tpls_cell.sv]
`timescale 1ns / 1ps

module tpls_cell #(
  parameter int D     = 1,
  parameter int STEPS = 256,
  parameter int LIM   = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tpls_pkg::tpls_pipe_t pipe_i,
  output tpls_pkg::tpls_pipe_t pipe_o
);
  import tpls_pkg::*;

  localparam int NW = $clog2(LIM * STEPS);
  localparam logic [31:0] RECIP = 32'(64'hFFFF_FFFF / D);
  localparam bit LAST = (D == STEPS);

  tpls_pipe_t         pipe_a_r;
  tpls_pipe_t         pipe_b_r, pipe_b_nxt;
  logic [NW-1:0]      q0_r;
  logic [NW+31:0]     prod;
  logic [NW-1:0]      r0, r, q;
  logic               enable;

  // quotient estimate, low by at most one
  assign prod = (NW+32)'(pipe_i.count[NW-1:0]) * (NW+32)'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_a_r.valid <= 1'b0;
    end else begin
      pipe_a_r.valid <= pipe_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    pipe_a_r.mode  <= pipe_i.mode;
    pipe_a_r.match <= pipe_i.match;
    pipe_a_r.count <= pipe_i.count;
    pipe_a_r.fit   <= pipe_i.fit;
    pipe_a_r.err   <= pipe_i.err;
    pipe_a_r.div   <= pipe_i.div;
    pipe_a_r.q     <= pipe_i.q;
    q0_r           <= prod[NW+31:32];
  end

  always_comb begin
    pipe_b_nxt = pipe_a_r;
    r0 = pipe_a_r.count[NW-1:0] - q0_r * NW'(D);
    if (r0 >= NW'(D)) begin
      q = q0_r + NW'(1);
      r = r0 - NW'(D);
    end else begin
      q = q0_r;
      r = r0;
    end
    enable = pipe_a_r.valid && pipe_a_r.mode && !(|pipe_a_r.count[31:NW])
             && !(pipe_a_r.match && LAST);
    if (enable && (q < NW'(LIM)) && ({1'b0, r[7:0]} < pipe_a_r.err)) begin
      pipe_b_nxt.fit = 1'b1;
      pipe_b_nxt.err = {1'b0, r[7:0]};
      pipe_b_nxt.div = DivW'(D);
      pipe_b_nxt.q   = q[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_b_r.valid <= 1'b0;
    end else begin
      pipe_b_r.valid <= pipe_b_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    pipe_b_r.mode  <= pipe_b_nxt.mode;
    pipe_b_r.match <= pipe_b_nxt.match;
    pipe_b_r.count <= pipe_b_nxt.count;
    pipe_b_r.fit   <= pipe_b_nxt.fit;
    pipe_b_r.err   <= pipe_b_nxt.err;
    pipe_b_r.div   <= pipe_b_nxt.div;
    pipe_b_r.q     <= pipe_b_nxt.q;
  end

  assign pipe_o = pipe_b_r;

endmodule

[hdl/timer_prescale_load_search_core.sv]
`timescale 1ns / 1ps
// Timer prescaler / load factorization core.
// Input: a word on in_data (operation, requested_count) is taken when start
// is high and busy is low. busy is never raised, so a word may be issued
// every cycle.
// Output: each word yields one result word on out_data, marked by out_valid
// for exactly one cycle. The receiver cannot stall; results must be taken.
// Config: counter_mode is written through cfg_data when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write only while idle.
// Path: an input register, then the chain of divisor cells, one cell per
// divisor with a multiply stage and a remainder/compare stage each, then an
// output register.
// Throughput: one word per cycle.
// Reset: synchronous, active low; clears counter_mode to 0 and all valid
// bits in the chain, dropping words in flight.
module timer_prescale_load_search_core #(
  parameter int PRESCALE_STEPS = 256,
  parameter int LOAD_LIMIT     = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tpls_pkg::tpls_in_t  in_data,
  output logic                out_valid,
  output tpls_pkg::tpls_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import tpls_pkg::*;

  logic       mode_r;
  tpls_pipe_t chain [0:PRESCALE_STEPS];
  tpls_pipe_t head_r;
  tpls_pipe_t tail;
  logic       out_valid_r;
  tpls_out_t  out_data_r, out_data_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.valid <= 1'b0;
    end else begin
      head_r.valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    head_r.mode  <= mode_r;
    head_r.match <= in_data.operation;
    head_r.count <= in_data.requested_count;
    head_r.fit   <= 1'b0;
    head_r.err   <= '1;
    head_r.div   <= '0;
    head_r.q     <= '0;
  end

  assign chain[0] = head_r;

  for (genvar i = 1; i <= PRESCALE_STEPS; i++) begin : g_cell
    tpls_cell #(
      .D     (i),
      .STEPS (PRESCALE_STEPS),
      .LIM   (LOAD_LIMIT)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .pipe_i (chain[i-1]),
      .pipe_o (chain[i])
    );
  end

  assign tail = chain[PRESCALE_STEPS];

  always_comb begin
    out_data_nxt = '0;
    if (!tail.mode) begin
      out_data_nxt.load_value = tail.match ? tail.count : tail.count - 32'd1;
      out_data_nxt.fit_found  = 1'b1;
    end else if (tail.fit) begin
      out_data_nxt.prescale_value = tail.match ? tail.div[7:0] : 8'(tail.div - DivW'(1));
      out_data_nxt.load_value     = tail.match ? 32'(tail.q) : 32'(tail.q) - 32'd1;
      out_data_nxt.remainder      = 32'(tail.err);
      out_data_nxt.fit_found      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/tpls_checker.sv]
`timescale 1ns / 1ps
`include "timer_prescale_load_search_core_macros.svh"

module tpls_checker #(
  parameter int LATENCY = 514
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input tpls_pkg::tpls_out_t out_data
);
  import tpls_pkg::*;

  `TPLS_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid)
  `TPLS_ASSERT(a_fixed_latency, clk, rst_n, (start && !busy) |-> ##LATENCY out_valid)
  `TPLS_ASSERT(a_nofit_zero, clk, rst_n,
    (out_valid && !out_data.fit_found) |-> (out_data.prescale_value == 8'd0 &&
    out_data.load_value == 32'd0 && out_data.remainder == 32'd0))
  `TPLS_ASSERT(a_rem_small, clk, rst_n, out_valid |-> (out_data.remainder[31:8] == 24'd0))

endmodule

bind timer_prescale_load_search_core tpls_checker #(
  .LATENCY (2 * PRESCALE_STEPS + 2)
) u_tpls_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
